// ===== rtl/core/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared constants, types and state codes of the shortest-seek-first
// disk request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

   // Capacity of the request store
   localparam int MAX_REQUESTS = 32;
   // Track number width (request tracks, head position)
   localparam int TRACK_W      = 16;
   // Seek distance width
   localparam int DIST_W       = TRACK_W;
   // Running total width
   localparam int TOTAL_W      = 21;

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

   // Input op codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_EMPTY
   } sstf_state_type;

   typedef struct packed {
      logic [TRACK_W-1:0] track_served;
      logic [DIST_W-1:0]  seek_distance;
      logic [TOTAL_W-1:0] total_distance;
      logic               last;
      logic               empty_run;
   } sstf_result_type;

endpackage

// ===== rtl/core/sstf_req_ram.sv =====
// ----------------------------------------------------------------------------
// sstf_req_ram
// Request track store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_req_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [sstf_pkg::IDX_W-1:0]       wr_addr,
   input  logic [sstf_pkg::TRACK_W-1:0]     wr_data,
   input  logic                             rd_en,
   input  logic [sstf_pkg::IDX_W-1:0]       rd_addr,
   output logic [sstf_pkg::TRACK_W-1:0]     rd_data
);

   logic [sstf_pkg::TRACK_W-1:0] mem [sstf_pkg::MAX_REQUESTS];
   logic [sstf_pkg::TRACK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sstf_engine.sv =====
// ----------------------------------------------------------------------------
// sstf_engine
// Load and run sequencer: fills the request store, then sweeps it once per
// selection to find the nearest unserved track and hands out one result word
// per service.
// ----------------------------------------------------------------------------
module sstf_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_op,
   input  logic [sstf_pkg::TRACK_W-1:0]      req_track,
   output logic                              req_ready,
   output logic                              res_valid,
   input  logic                              res_ready,
   output sstf_pkg::sstf_result_type         res_word
);

   sstf_pkg::sstf_state_type state_ff, state_in;

   logic [sstf_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [sstf_pkg::CNT_W-1:0]        issue_ff, issue_in;
   logic [sstf_pkg::CNT_W-1:0]        served_ff, served_in;
   logic [sstf_pkg::MAX_REQUESTS-1:0] valid_ff, valid_in;
   logic [sstf_pkg::TRACK_W-1:0]      head_ff, head_in;
   logic [sstf_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic                              cmp_vld_ff, cmp_vld_in;
   logic [sstf_pkg::IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                              best_found_ff, best_found_in;
   logic [sstf_pkg::IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [sstf_pkg::TRACK_W-1:0]      best_trk_ff, best_trk_in;
   logic [sstf_pkg::DIST_W-1:0]       best_dist_ff, best_dist_in;

   logic                              ram_wr_en;
   logic [sstf_pkg::IDX_W-1:0]        ram_wr_addr;
   logic [sstf_pkg::TRACK_W-1:0]      ram_wr_data;
   logic                              ram_rd_en;
   logic [sstf_pkg::IDX_W-1:0]        ram_rd_addr;
   logic [sstf_pkg::TRACK_W-1:0]      ram_rd_data;

   logic [sstf_pkg::DIST_W-1:0]       cur_dist;
   logic                              cur_take;
   logic                              last_step;
   logic [sstf_pkg::TOTAL_W-1:0]      total_next;

   sstf_req_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Distance of the entry read last cycle; keep the first minimum on ties
   assign cur_dist = (ram_rd_data >= head_ff) ? (ram_rd_data - head_ff)
                                              : (head_ff - ram_rd_data);
   assign cur_take = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                     (!best_found_ff || (cur_dist < best_dist_ff));
   assign last_step  = (sstf_pkg::CNT_W'(served_ff + sstf_pkg::CNT_W'(1)) == count_ff);
   assign total_next = total_ff + sstf_pkg::TOTAL_W'(best_dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sstf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         valid_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         cmp_vld_ff    <= cmp_vld_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      served_ff    <= served_in;
      head_ff      <= head_in;
      total_ff     <= total_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_trk_ff  <= best_trk_in;
      best_dist_ff <= best_dist_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      served_in     = served_ff;
      valid_in      = valid_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_trk_in   = best_trk_ff;
      best_dist_in  = best_dist_ff;

      req_ready   = 1'b0;
      res_valid   = 1'b0;
      res_word    = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[sstf_pkg::IDX_W-1:0];
      ram_wr_data = req_track;
      ram_rd_en   = 1'b0;
      ram_rd_addr = issue_ff[sstf_pkg::IDX_W-1:0];

      // compare stage
      if (cur_take) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_trk_in   = ram_rd_data;
         best_dist_in  = cur_dist;
      end

      case (state_ff)
         sstf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == sstf_pkg::OP_LOAD) begin
                  if (count_ff < sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS)) begin
                     ram_wr_en = 1'b1;
                     valid_in[count_ff[sstf_pkg::IDX_W-1:0]] = 1'b1;
                     count_in  = count_ff + sstf_pkg::CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  state_in = sstf_pkg::ST_EMPTY;
               end else begin
                  head_in       = req_track;
                  total_in      = '0;
                  served_in     = '0;
                  issue_in      = '0;
                  best_found_in = 1'b0;
                  state_in      = sstf_pkg::ST_SCAN;
               end
            end
         end
         sstf_pkg::ST_SCAN: begin
            if (issue_ff < count_ff) begin
               ram_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[sstf_pkg::IDX_W-1:0];
               issue_in   = issue_ff + sstf_pkg::CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in = sstf_pkg::ST_EMIT;
            end
         end
         sstf_pkg::ST_EMIT: begin
            res_valid               = 1'b1;
            res_word.track_served   = best_trk_ff;
            res_word.seek_distance  = best_dist_ff;
            res_word.total_distance = total_next;
            res_word.last           = last_step;
            res_word.empty_run      = 1'b0;
            if (res_ready) begin
               valid_in[best_idx_ff] = 1'b0;
               head_in   = best_trk_ff;
               total_in  = total_next;
               served_in = served_ff + sstf_pkg::CNT_W'(1);
               if (last_step) begin
                  valid_in = '0;
                  count_in = '0;
                  state_in = sstf_pkg::ST_IDLE;
               end else begin
                  issue_in      = '0;
                  best_found_in = 1'b0;
                  state_in      = sstf_pkg::ST_SCAN;
               end
            end
         end
         sstf_pkg::ST_EMPTY: begin
            res_valid          = 1'b1;
            res_word.last      = 1'b1;
            res_word.empty_run = 1'b1;
            if (res_ready) begin
               state_in = sstf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sstf_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS))
      else $error("request count above capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstf_pkg::ST_SCAN) |-> (issue_ff <= count_ff))
      else $error("sweep address ran past the stored requests");

   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstf_pkg::ST_EMIT) |-> (best_found_ff && valid_ff[best_idx_ff]))
      else $error("service of an entry that is not pending");

   a_emit_served: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstf_pkg::ST_EMIT) |-> (served_ff < count_ff))
      else $error("more services than stored requests");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && res_word.last) |=> (valid_ff == '0 && count_ff == '0))
      else $error("store not emptied at end of run");
`endif

endmodule

// ===== rtl/core/sstf_disk_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_core
// Shortest-seek-first disk request scheduler: collects request tracks, then
// serves them nearest-first from a given head position.
//
//   channel  | handshake             | word
//   ---------+-----------------------+--------------------------------------
//   req_     | req_valid / req_ready | op, track (load track or head pos)
//   rsp_     | rsp_valid / rsp_ready | track_served, seek_distance,
//            |                       | total_distance, last, empty_run
//
// A start with N stored requests runs N selections; each selection sweeps
// the N store entries through the single read port of the request RAM,
// waits for the read data and the compare stage to drain, and then hands
// the word over. Reset clears the valid bits and the request count; no
// clearing pass over the RAM. A stalled rsp_ side holds the word in the
// output register; the engine waits until the register frees.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [sstf_pkg::TRACK_W-1:0]    req_track,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sstf_pkg::TRACK_W-1:0]    rsp_track_served,
   output logic [sstf_pkg::DIST_W-1:0]     rsp_seek_distance,
   output logic [sstf_pkg::TOTAL_W-1:0]    rsp_total_distance,
   output logic                            rsp_last,
   output logic                            rsp_empty_run
);

   logic                        res_valid;
   logic                        res_ready;
   sstf_pkg::sstf_result_type   res_word;

   logic                        rsp_valid_ff, rsp_valid_in;
   sstf_pkg::sstf_result_type   rsp_word_ff, rsp_word_in;

   sstf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_track (req_track),
      .req_ready (req_ready),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_word  (res_word)
   );

   // Take a new word when the output register is empty or drains this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_ready) begin
         // drop the delivered word
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload; no reset needed
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_track_served   = rsp_word_ff.track_served;
   assign rsp_seek_distance  = rsp_word_ff.seek_distance;
   assign rsp_total_distance = rsp_word_ff.total_distance;
   assign rsp_last           = rsp_word_ff.last;
   assign rsp_empty_run      = rsp_word_ff.empty_run;

endmodule

// ===== tb/sv/sstf_service_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sstf_service_checker
// Watches both channels of the disk scheduler and keeps its own copy of the
// request store. Each accepted start is expanded into the nearest-first
// service order. Returned words are compared field by field against it.
// ----------------------------------------------------------------------------
module sstf_service_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_op,
   input  logic [sstf_pkg::TRACK_W-1:0]    req_track,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [sstf_pkg::TRACK_W-1:0]    rsp_track_served,
   input  logic [sstf_pkg::DIST_W-1:0]     rsp_seek_distance,
   input  logic [sstf_pkg::TOTAL_W-1:0]    rsp_total_distance,
   input  logic                            rsp_last,
   input  logic                            rsp_empty_run,
   output int                              mismatch_count,
   output int                              pending_services,
   output int                              services_checked
);
   import sstf_pkg::*;

   logic [TRACK_W-1:0] track_store [MAX_REQUESTS];
   bit                 track_live  [MAX_REQUESTS];
   int unsigned        track_count;
   sstf_result_type    service_queue [$];

   initial begin
      mismatch_count   = 0;
      services_checked = 0;
      pending_services = 0;
   end

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("[%0t] service mismatch on %s: got %0d, want %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   // Store a load, or serve every stored track nearest-first from the head.
   task automatic serve_nearest_first(input logic op, input logic [TRACK_W-1:0] trk);
      logic [TRACK_W-1:0] head;
      logic [TOTAL_W-1:0] total;
      logic [DIST_W-1:0]  gap;
      logic [DIST_W-1:0]  best_dist;
      int                 best;
      sstf_result_type    svc;
      if (op == OP_LOAD) begin
         if (track_count < MAX_REQUESTS) begin
            track_store[track_count] = trk;
            track_live[track_count]  = 1'b1;
            track_count++;
         end
      end else if (track_count == 0) begin
         svc = '0;
         svc.last      = 1'b1;
         svc.empty_run = 1'b1;
         service_queue.push_back(svc);
      end else begin
         head  = trk;
         total = '0;
         for (int served = 0; served < track_count; served++) begin
            best      = -1;
            best_dist = '0;
            // strict less-than keeps the lowest index on a tie
            for (int i = 0; i < track_count; i++) begin
               if (track_live[i]) begin
                  gap = (track_store[i] >= head) ? track_store[i] - head
                                                 : head - track_store[i];
                  if (best < 0 || gap < best_dist) begin
                     best      = i;
                     best_dist = gap;
                  end
               end
            end
            total             = total + best_dist;
            head              = track_store[best];
            track_live[best]  = 1'b0;
            svc.track_served   = head;
            svc.seek_distance  = best_dist;
            svc.total_distance = total;
            svc.last           = (served + 1 == track_count);
            svc.empty_run      = 1'b0;
            service_queue.push_back(svc);
         end
         for (int i = 0; i < MAX_REQUESTS; i++) track_live[i] = 1'b0;
         track_count = 0;
      end
   endtask

   always @(posedge clock) begin
      sstf_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_REQUESTS; i++) track_live[i] = 1'b0;
         track_count = 0;
         service_queue.delete();
      end else begin
         if (req_valid && req_ready) serve_nearest_first(req_op, req_track);
         if (rsp_valid && rsp_ready) begin
            if (service_queue.size() == 0) begin
               report_mismatch("unexpected word, queue size", 1, 0);
            end else begin
               want = service_queue.pop_front();
               if (rsp_track_served !== want.track_served)
                  report_mismatch("track_served", rsp_track_served, want.track_served);
               if (rsp_seek_distance !== want.seek_distance)
                  report_mismatch("seek_distance", rsp_seek_distance, want.seek_distance);
               if (rsp_total_distance !== want.total_distance)
                  report_mismatch("total_distance", rsp_total_distance,
                                  want.total_distance);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
               if (rsp_empty_run !== want.empty_run)
                  report_mismatch("empty_run", rsp_empty_run, want.empty_run);
               services_checked++;
            end
         end
      end
      pending_services <= service_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and start words into the shortest-seek-first scheduler under
// random sender gaps and receiver stalls. The checker instance predicts and
// compares every service word. This module only makes stimulus and gives
// the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import sstf_pkg::*;

   localparam int RANDOM_ITEMS = 350;
   localparam int DRAIN_CYCLES = 64;
   // Room for full runs of 32 services, stretched by heavy stalls
   localparam int CYCLE_LIMIT  = 2000000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [TRACK_W-1:0]  req_track;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [TRACK_W-1:0]  rsp_track_served;
   logic [DIST_W-1:0]   rsp_seek_distance;
   logic [TOTAL_W-1:0]  rsp_total_distance;
   logic                rsp_last;
   logic                rsp_empty_run;

   int mismatch_count;
   int pending_services;
   int services_checked;

   int words_sent   = 0;
   int starts_sent  = 0;
   int cycle_count  = 0;
   int tx_idle_pct  = 20;
   int rx_stall_pct = 79;

   sstf_disk_scheduler_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_track          (req_track),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_track_served   (rsp_track_served),
      .rsp_seek_distance  (rsp_seek_distance),
      .rsp_total_distance (rsp_total_distance),
      .rsp_last           (rsp_last),
      .rsp_empty_run      (rsp_empty_run)
   );

   sstf_service_checker svc_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_track          (req_track),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_track_served   (rsp_track_served),
      .rsp_seek_distance  (rsp_seek_distance),
      .rsp_total_distance (rsp_total_distance),
      .rsp_last           (rsp_last),
      .rsp_empty_run      (rsp_empty_run),
      .mismatch_count     (mismatch_count),
      .pending_services   (pending_services),
      .services_checked   (services_checked)
   );

   // 4 ns period
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Stall the result side at the current rate; hold it low through reset.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rx_stall_pct);
   end

   // Watchdog: end the run if the scheduler stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d service words still due",
                  cycle_count, pending_services);
         $display("Mismatches found");
         $finish;
      end
   end

   // Send one word. Drop valid only for idle cycles; otherwise keep it high
   // and just swap the payload, so valid never falls and rises in one step.
   task automatic send_word(input logic op, input logic [TRACK_W-1:0] trk);
      // Three idling phases: slow receiver, then slow sender, then no gaps.
      if (words_sent < 125) begin
         tx_idle_pct  = 20;
         rx_stall_pct = 79;
      end else if (words_sent < 250) begin
         tx_idle_pct  = 79;
         rx_stall_pct = 20;
      end else begin
         tx_idle_pct  = 0;
         rx_stall_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_track <= trk;
      // Hold the word until the edge where ready is seen high.
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (op == OP_START) starts_sent++;
   endtask

   // Mix corner tracks, a cluster around a base (ties and repeats) and noise.
   function automatic logic [TRACK_W-1:0] pick_track(input logic [TRACK_W-1:0] base);
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return base + TRACK_W'($urandom_range(6));
         default: return TRACK_W'($urandom);
      endcase
   endfunction

   initial begin
      int                 n;
      logic [TRACK_W-1:0] base;
      logic [TRACK_W-1:0] head;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_op    <= OP_LOAD;
      req_track <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Start with nothing stored: one empty-run word.
      send_word(OP_START, 16'hFFFF);
      // Extreme tracks; from 40000 serve 32768, then 65535, then 0.
      send_word(OP_LOAD, 16'hFFFF);
      send_word(OP_LOAD, 16'h0000);
      send_word(OP_LOAD, 16'h8000);
      send_word(OP_START, 16'd40000);
      // Equal distance both ways: the earlier stored track wins.
      send_word(OP_LOAD, 16'd300);
      send_word(OP_LOAD, 16'd100);
      send_word(OP_START, 16'd200);
      // Repeated tracks under the head: zero seeks.
      send_word(OP_LOAD, 16'd500);
      send_word(OP_LOAD, 16'd500);
      send_word(OP_LOAD, 16'd7);
      send_word(OP_START, 16'd500);
      // Full-span seek in both directions.
      send_word(OP_LOAD, 16'h0000);
      send_word(OP_START, 16'hFFFF);
      send_word(OP_LOAD, 16'hFFFF);
      send_word(OP_START, 16'h0000);
      // Back-to-back starts: the second finds the store cleared.
      send_word(OP_START, 16'h1234);

      // Mostly well-formed load batches followed by a start; a few batches
      // overfill the store, and stray starts land on an empty store.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 10) begin
            send_word(OP_START, TRACK_W'($urandom));
            n++;
         end else begin
            base = TRACK_W'($urandom);
            for (int k = ($urandom_range(99) < 8) ? $urandom_range(30, 40)
                                                 : $urandom_range(1, 10);
                 k > 0; k--) begin
               send_word(OP_LOAD, pick_track(base));
               n++;
            end
            head = ($urandom_range(9) < 3) ? base + TRACK_W'($urandom_range(6))
                                           : pick_track(base);
            send_word(OP_START, head);
            n++;
         end
      end
      req_valid <= 1'b0;

      // Let the checker see the last start, then drain.
      @(posedge clock);
      while (pending_services != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words including %0d starts; checked %0d service words",
               words_sent, starts_sent, services_checked);
      $display("covering empty runs, ties, repeated tracks and overfilled stores");
      if (mismatch_count == 0 && pending_services == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sstf_pkg.sv
rtl/core/sstf_req_ram.sv
rtl/core/sstf_engine.sv
rtl/core/sstf_disk_scheduler_core.sv
tb/sv/sstf_service_checker.sv
tb/sv/testbench.sv
